### design/dnp_pkg.sv
package dnp_pkg;

    // Parse phase codes
    localparam logic [2:0] PH_START = 3'd0;  // expecting sign or first digit
    localparam logic [2:0] PH_INT   = 3'd1;  // integer digits
    localparam logic [2:0] PH_FRAC  = 3'd2;  // fraction digits
    localparam logic [2:0] PH_ESIGN = 3'd3;  // right after 'e'
    localparam logic [2:0] PH_EDIG  = 3'd4;  // exponent digits
    localparam logic [2:0] PH_DONE  = 3'd5;  // stopped, skip to NUL

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Width of the exponent10 result field and of the input character
    localparam int EXP10_W = 16;
    localparam int CHAR_W  = 8;

    typedef struct packed {
        logic [2:0] phase;
        logic       sign_flag;
        logic       exp_negative;
        logic       have_digits;
    } parse_ctrl_t;

endpackage

### design/dnp_step.sv
// One character step of the parser: next control, coefficient and exponent
// state, plus the combined base-10 exponent of the current state.
module dnp_step #(
    parameter int COEFF_BITS = 64,
    parameter int EXP_BITS   = 16
) (
    input  dnp_pkg::parse_ctrl_t   ctrl,
    input  logic [COEFF_BITS-1:0]  accum,
    input  logic [EXP_BITS-1:0]    exp_total,
    input  logic [EXP_BITS-1:0]    exp_digits,
    input  logic [dnp_pkg::CHAR_W-1:0] ch,
    output dnp_pkg::parse_ctrl_t   ctrl_next,
    output logic [COEFF_BITS-1:0]  accum_next,
    output logic [EXP_BITS-1:0]    exp_total_next,
    output logic [EXP_BITS-1:0]    exp_digits_next,
    output logic [EXP_BITS-1:0]    exp_final
);

    logic                  is_digit;
    logic [3:0]            dig;
    logic [COEFF_BITS-1:0] accum_dig;
    logic [EXP_BITS-1:0]   edig_dig;

    // '0'..'9' carry their value in the low nibble
    assign is_digit  = ch inside {[dnp_pkg::CH_ZERO:dnp_pkg::CH_NINE]};
    assign dig       = ch[3:0];
    assign accum_dig = (accum << 3) + (accum << 1) + COEFF_BITS'(dig);
    assign edig_dig  = (exp_digits << 3) + (exp_digits << 1) + EXP_BITS'(dig);

    assign exp_final = ctrl.exp_negative ? (exp_total - exp_digits)
                                         : (exp_total + exp_digits);

    always_comb begin
        ctrl_next       = ctrl;
        accum_next      = accum;
        exp_total_next  = exp_total;
        exp_digits_next = exp_digits;
        case (ctrl.phase)
            dnp_pkg::PH_START: begin
                if (ch == dnp_pkg::CH_PLUS) begin
                    ctrl_next.phase = dnp_pkg::PH_INT;
                end else if (ch == dnp_pkg::CH_MINUS) begin
                    ctrl_next.sign_flag = 1'b1;
                    ctrl_next.phase     = dnp_pkg::PH_INT;
                end else if (is_digit) begin
                    accum_next            = accum_dig;
                    ctrl_next.have_digits = 1'b1;
                    ctrl_next.phase       = dnp_pkg::PH_INT;
                end else begin
                    ctrl_next.phase = dnp_pkg::PH_DONE;
                end
            end
            dnp_pkg::PH_INT: begin
                if (is_digit) begin
                    accum_next            = accum_dig;
                    ctrl_next.have_digits = 1'b1;
                end else if (ctrl.have_digits && ch == dnp_pkg::CH_DOT) begin
                    ctrl_next.phase = dnp_pkg::PH_FRAC;
                end else if (ctrl.have_digits && ch == dnp_pkg::CH_E) begin
                    ctrl_next.phase = dnp_pkg::PH_ESIGN;
                end else begin
                    ctrl_next.phase = dnp_pkg::PH_DONE;
                end
            end
            dnp_pkg::PH_FRAC: begin
                if (is_digit) begin
                    accum_next     = accum_dig;
                    exp_total_next = exp_total - EXP_BITS'(1);
                end else if (ch == dnp_pkg::CH_E) begin
                    ctrl_next.phase = dnp_pkg::PH_ESIGN;
                end else begin
                    ctrl_next.phase = dnp_pkg::PH_DONE;
                end
            end
            dnp_pkg::PH_ESIGN: begin
                if (ch == dnp_pkg::CH_PLUS) begin
                    ctrl_next.phase = dnp_pkg::PH_EDIG;
                end else if (ch == dnp_pkg::CH_MINUS) begin
                    ctrl_next.exp_negative = 1'b1;
                    ctrl_next.phase        = dnp_pkg::PH_EDIG;
                end else if (is_digit) begin
                    exp_digits_next = edig_dig;
                    ctrl_next.phase = dnp_pkg::PH_EDIG;
                end else begin
                    ctrl_next.phase = dnp_pkg::PH_DONE;
                end
            end
            dnp_pkg::PH_EDIG: begin
                if (is_digit) begin
                    exp_digits_next = edig_dig;
                end else begin
                    ctrl_next.phase = dnp_pkg::PH_DONE;
                end
            end
            default: begin
                ctrl_next.phase = dnp_pkg::PH_DONE;
            end
        endcase
    end

endmodule

### design/decimal_number_parser_core.sv
// Decimal number text parser.
// Input stream (s_*): one character per request in s_tdata; a NUL character
//   closes the number. Form: [+|-] digits [. digits] [e [+|-] digits].
//   The first character that does not fit stops parsing; the rest up to the
//   NUL is skipped. Missing integer digits raise the error bit.
// Result stream (m_*): one request per NUL, carrying sign, coefficient
//   (mod 2^COEFF_BITS), base-10 exponent (mod 2^EXP_BITS, sign-extended or
//   cut to its low bits to fit 16 bits) and the error bit.
// Throughput: one character per cycle while s_tready is high. Each character is folded into the
//   parse state registers in the cycle it is accepted (one multiply-by-ten
//   add on the coefficient); the NUL loads the result register directly.
// Latency: the result is valid the cycle after its NUL is accepted.
// Stall: the result register holds while m_tready is low; s_tready drops
//   only while a result is held and not being taken, so characters keep
//   flowing as long as the result side drains.
// Reset (aresetn low, synchronous): parse state returns to start, the
//   result register is emptied.
module decimal_number_parser_core #(
    parameter int COEFF_BITS = 64,
    parameter int EXP_BITS   = 16
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dnp_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] ch

    output logic                        m_tvalid,
    input  logic                        m_tready,
    // from bit 0: negative, coefficient, exponent10, error; zero-padded
    output logic [((COEFF_BITS + dnp_pkg::EXP10_W + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int FIELD_W = 1 + COEFF_BITS + dnp_pkg::EXP10_W + 1;
    localparam int OUT_W   = ((FIELD_W + 7) / 8) * 8;

    // Parse state
    dnp_pkg::parse_ctrl_t   ctrl_reg,       ctrl_next;
    logic [COEFF_BITS-1:0]  accum_reg,      accum_next;
    logic [EXP_BITS-1:0]    exp_total_reg,  exp_total_next;
    logic [EXP_BITS-1:0]    exp_digits_reg, exp_digits_next;
    logic [EXP_BITS-1:0]    exp_final;
    logic [dnp_pkg::EXP10_W-1:0] exp10;

    // Result register
    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;
    logic [OUT_W-1:0]       m_tdata_next;

    logic                   s_accept;
    logic                   nul_accept;

    localparam dnp_pkg::parse_ctrl_t CTRL_RESET = '{
        phase:        dnp_pkg::PH_START,
        sign_flag:    1'b0,
        exp_negative: 1'b0,
        have_digits:  1'b0
    };

    assign s_tready   = !m_tvalid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign nul_accept = s_accept && (s_tdata == dnp_pkg::CH_NUL);

    dnp_step #(
        .COEFF_BITS (COEFF_BITS),
        .EXP_BITS   (EXP_BITS)
    ) u_step (
        .ctrl            (ctrl_reg),
        .accum           (accum_reg),
        .exp_total       (exp_total_reg),
        .exp_digits      (exp_digits_reg),
        .ch              (s_tdata),
        .ctrl_next       (ctrl_next),
        .accum_next      (accum_next),
        .exp_total_next  (exp_total_next),
        .exp_digits_next (exp_digits_next),
        .exp_final       (exp_final)
    );

    // Exponent to the 16-bit result field: sign-extend or keep low bits
    generate
        if (EXP_BITS >= dnp_pkg::EXP10_W) begin : g_exp_trunc
            assign exp10 = exp_final[dnp_pkg::EXP10_W-1:0];
        end else begin : g_exp_sext
            assign exp10 = {{(dnp_pkg::EXP10_W - EXP_BITS){exp_final[EXP_BITS-1]}},
                            exp_final};
        end
    endgenerate

    assign m_tdata_next = OUT_W'({!ctrl_reg.have_digits, exp10, accum_reg,
                                  ctrl_reg.sign_flag});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg       <= CTRL_RESET;
            accum_reg      <= '0;
            exp_total_reg  <= '0;
            exp_digits_reg <= '0;
        end else if (nul_accept) begin
            // number closed: back to start for the next one
            ctrl_reg       <= CTRL_RESET;
            accum_reg      <= '0;
            exp_total_reg  <= '0;
            exp_digits_reg <= '0;
        end else if (s_accept) begin
            ctrl_reg       <= ctrl_next;
            accum_reg      <= accum_next;
            exp_total_reg  <= exp_total_next;
            exp_digits_reg <= exp_digits_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (nul_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (nul_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A closing NUL always produces a result next cycle
    a_nul_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        nul_accept |=> m_tvalid)
        else $error("no result after closing NUL");

    // A result only appears because of a closing NUL
    a_result_from_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(nul_accept))
        else $error("result without closing NUL");

    // After a number closes, the parser starts fresh
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        nul_accept |=> (ctrl_reg.phase == dnp_pkg::PH_START) && (accum_reg == '0)
                       && !ctrl_reg.have_digits)
        else $error("parse state not cleared after NUL");

    // A stopped parse stays stopped until its NUL
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_reg.phase == dnp_pkg::PH_DONE) && !nul_accept
        |=> (ctrl_reg.phase == dnp_pkg::PH_DONE))
        else $error("left stopped phase before NUL");

endmodule
